// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the classifier RTL.
// Needs signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every edge outside reset
`define CSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// trigger on one edge, expectation on the next
`define CSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

// ===== hw/rtl/csc_pkg.sv =====
// Shared types and constants for the cube/sphere classifier.
// No dependencies.
`default_nettype none
package csc_pkg;
  localparam int MID_DEPTH = 8;
  localparam int MID_AW    = 3;
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = 3;

  localparam logic CFG_CELL_EDGE = 1'b0;
  localparam logic CFG_HALF_DIAG = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_BURIED = 2'd0,
    VERDICT_CROSS  = 2'd1,
    VERDICT_CLEAR  = 2'd2
  } verdict_t;

  // front -> back request: early verdict or operands of the face test
  typedef struct packed {
    logic               done;
    verdict_t           verdict;
    logic [35:0]        d2;
    logic [35:0]        compsq;
    logic signed [21:0] dper;
    logic [33:0]        sg2;
    logic [27:0]        hh;
  } mid_entry_t;
endpackage
`default_nettype wire

// ===== hw/rtl/cube_sphere_classify_unit.sv =====
// Top level of the cube/sphere classifier: config registers, credit control.
// Depends on csc_pkg, csc_front, csc_queue, csc_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Classifies a cubic grid cell against a sphere (atom radius plus probe) and
// returns one verdict per request: 0 buried, 1 crossing, 2 clear. Requests
// are taken one per clock; a request is pushed when in_push is high and
// in_full low, and its verdict appears in request order. The front part
// (three stages) checks the centre distance against radius plus/minus half
// diagonal, counts corners inside and picks the nearest face; a short queue
// then feeds the back part (four stages), which runs the face disc test with
// the wide products split into partial products, and writes an 8-entry
// result queue. Full rate holds as long as results are popped; in_full
// rises once eight requests wait in the front stages and the mid queue.
// The user must write cell_edge and half_diagonal via cfg_we/cfg_index/cfg_wdata
// only while no request is in flight; the block does not enforce this.
module cube_sphere_classify_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic signed [23:0] in_cell_x,
  input  wire logic signed [23:0] in_cell_y,
  input  wire logic signed [23:0] in_cell_z,
  input  wire logic signed [23:0] in_ball_x,
  input  wire logic signed [23:0] in_ball_y,
  input  wire logic signed [23:0] in_ball_z,
  input  wire logic [15:0]        in_ball_radius,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [1:0]              out_verdict,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [13:0]        cfg_wdata
);
  logic [13:0]                 cell_edge_r, half_diag_r;
  logic [csc_pkg::MID_AW:0]    mid_used_r, mid_used_nxt;
  logic                        in_accept;
  logic                        mid_push, mid_pop, mid_empty;
  csc_pkg::mid_entry_t         front_data, queue_data;

  // config registers, reset to a 2 A cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_edge_r <= 14'd8192;
      half_diag_r <= 14'd7094;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csc_pkg::CFG_CELL_EDGE: cell_edge_r <= cfg_wdata;
        csc_pkg::CFG_HALF_DIAG: half_diag_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // credits cover the front stages plus the mid queue, so it never overflows
  assign in_full   = (mid_used_r == (csc_pkg::MID_AW+1)'(csc_pkg::MID_DEPTH));
  assign in_accept = in_push && !in_full;
  assign mid_used_nxt = mid_used_r + {{csc_pkg::MID_AW{1'b0}}, in_accept}
                      - {{csc_pkg::MID_AW{1'b0}}, mid_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_used_r <= '0;
    end else begin
      mid_used_r <= mid_used_nxt;
    end
  end

  csc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_accept),
    .cell_x     (in_cell_x),
    .cell_y     (in_cell_y),
    .cell_z     (in_cell_z),
    .ball_x     (in_ball_x),
    .ball_y     (in_ball_y),
    .ball_z     (in_ball_z),
    .ball_radius(in_ball_radius),
    .cell_edge  (cell_edge_r),
    .half_diag  (half_diag_r),
    .mid_push   (mid_push),
    .mid_data   (front_data)
  );

  csc_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_push),
    .din  (front_data),
    .pop  (mid_pop),
    .empty(mid_empty),
    .dout (queue_data)
  );

  csc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_empty  (mid_empty),
    .mid_data   (queue_data),
    .mid_pop    (mid_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_verdict(out_verdict)
  );

  `CSC_ASSERT(a_credit_bound, mid_used_r <= (csc_pkg::MID_AW+1)'(csc_pkg::MID_DEPTH), "credit overrun")
  `CSC_ASSERT(a_pop_nonempty, mid_pop |-> !mid_empty, "pop from empty mid queue")
  `CSC_ASSERT_NEXT(a_credit_take, in_accept && !mid_pop, mid_used_r == $past(mid_used_r) + 1'b1, "credit not taken")
  `CSC_ASSERT(a_verdict_code, !out_empty |-> (out_verdict == csc_pkg::VERDICT_BURIED || out_verdict == csc_pkg::VERDICT_CROSS || out_verdict == csc_pkg::VERDICT_CLEAR), "bad verdict")
endmodule
`default_nettype wire

// ===== hw/rtl/csc_queue.sv =====
// Short register queue between the front and back parts.
// Depends on csc_pkg.
`default_nettype none
module csc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire csc_pkg::mid_entry_t   din,
  input  wire logic                  pop,
  output logic                       empty,
  output csc_pkg::mid_entry_t        dout
);
  csc_pkg::mid_entry_t                mem_r [csc_pkg::MID_DEPTH];
  logic [csc_pkg::MID_AW-1:0]         wp_r, rp_r;
  logic [csc_pkg::MID_AW:0]           cnt_r;

  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{csc_pkg::MID_AW{1'b0}}, push} - {{csc_pkg::MID_AW{1'b0}}, pop};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/csc_front.sv =====
// Front part: distance bounds, corner count and nearest face pick, three stages.
// Depends on csc_pkg.
`default_nettype none
module csc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic signed [23:0]  cell_x,
  input  wire logic signed [23:0]  cell_y,
  input  wire logic signed [23:0]  cell_z,
  input  wire logic signed [23:0]  ball_x,
  input  wire logic signed [23:0]  ball_y,
  input  wire logic signed [23:0]  ball_z,
  input  wire logic [15:0]         ball_radius,
  input  wire logic [13:0]         cell_edge,
  input  wire logic [13:0]         half_diag,
  output logic                     mid_push,
  output csc_pkg::mid_entry_t      mid_data
);
  // stage 1
  logic                v1_r;
  logic signed [25:0]  d1_r [3];
  logic signed [20:0]  em1_r [3], ep1_r [3];
  logic [16:0]         sg1_r, diff1_r;
  logic [17:0]         sum1_r;
  logic [13:0]         h1_r;
  logic signed [24:0]  dd [3];
  logic signed [25:0]  d_nxt [3];
  logic signed [20:0]  em_nxt [3], ep_nxt [3];
  logic [16:0]         sg_nxt;
  logic [17:0]         sdiff;

  // stage 2
  logic                v2_r;
  logic [51:0]         sq2_r [3];
  logic [39:0]         cm2_r [3], cp2_r [3];
  logic [35:0]         sum2_r;
  logic [33:0]         diff2_r, sg2_r;
  logic [27:0]         hh2_r;
  logic [13:0]         h2_r;
  logic [20:0]         dmin2_r;
  logic [1:0]          best2_r;
  logic [51:0]         sq_nxt [3];
  logic [39:0]         cm_nxt [3], cp_nxt [3];
  logic signed [51:0]  psq;
  logic signed [41:0]  pc;
  logic [20:0]         fabs [6];
  logic [20:0]         dmin_nxt;
  logic [1:0]          best_nxt;

  // stage 3
  logic                v3_r;
  csc_pkg::mid_entry_t ent3_r, ent_nxt;
  logic [53:0]         d2;
  logic [41:0]         csum;
  logic [7:0]          corner_in;
  logic [51:0]         compsq;
  logic                clr, bur;

  assign dd[0] = {cell_x[23], cell_x} - {ball_x[23], ball_x};
  assign dd[1] = {cell_y[23], cell_y} - {ball_y[23], ball_y};
  assign dd[2] = {cell_z[23], cell_z} - {ball_z[23], ball_z};
  assign sg_nxt = {ball_radius, 1'b0};
  assign sdiff  = {1'b0, sg_nxt} - {3'b0, half_diag, 1'b0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i]  = {dd[i], 1'b0};
      // narrow copies, valid whenever the distance bounds do not decide
      em_nxt[i] = {dd[i][18], dd[i][18:0], 1'b0} - {7'b0, cell_edge};
      ep_nxt[i] = {dd[i][18], dd[i][18:0], 1'b0} + {7'b0, cell_edge};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d1_r[i]  <= d_nxt[i];
      em1_r[i] <= em_nxt[i];
      ep1_r[i] <= ep_nxt[i];
    end
    sg1_r   <= sg_nxt;
    sum1_r  <= {1'b0, sg_nxt} + {3'b0, half_diag, 1'b0};
    diff1_r <= sdiff[17] ? 17'(-sdiff) : sdiff[16:0];
    h1_r    <= cell_edge;
  end

  always_comb begin
    psq = '0;
    pc  = '0;
    for (int i = 0; i < 3; i++) begin
      psq       = d1_r[i] * d1_r[i];
      sq_nxt[i] = psq;
      pc        = em1_r[i] * em1_r[i];
      cm_nxt[i] = pc[39:0];
      pc        = ep1_r[i] * ep1_r[i];
      cp_nxt[i] = pc[39:0];
      fabs[2*i]   = em1_r[i][20] ? 21'(-em1_r[i]) : em1_r[i];
      fabs[2*i+1] = ep1_r[i][20] ? 21'(-ep1_r[i]) : ep1_r[i];
    end
    // faces x-, x+, y-, y+, z-, z+; first smallest wins
    dmin_nxt = fabs[0];
    best_nxt = 2'd0;
    for (int k = 1; k < 6; k++) begin
      if (fabs[k] < dmin_nxt) begin
        dmin_nxt = fabs[k];
        best_nxt = 2'(k / 2);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq2_r[i] <= sq_nxt[i];
      cm2_r[i] <= cm_nxt[i];
      cp2_r[i] <= cp_nxt[i];
    end
    sum2_r  <= sum1_r * sum1_r;
    diff2_r <= diff1_r * diff1_r;
    sg2_r   <= sg1_r * sg1_r;
    hh2_r   <= h1_r * h1_r;
    h2_r    <= h1_r;
    dmin2_r <= dmin_nxt;
    best2_r <= best_nxt;
  end

  always_comb begin
    d2  = {2'b0, sq2_r[0]} + {2'b0, sq2_r[1]} + {2'b0, sq2_r[2]};
    clr = d2 > {18'b0, sum2_r};
    bur = d2 < {20'b0, diff2_r};
    for (int k = 0; k < 8; k++) begin
      csum = {2'b0, ((k & 1) != 0) ? cp2_r[0] : cm2_r[0]}
           + {2'b0, ((k & 2) != 0) ? cp2_r[1] : cm2_r[1]}
           + {2'b0, ((k & 4) != 0) ? cp2_r[2] : cm2_r[2]};
      corner_in[k] = csum < {8'b0, sg2_r};
    end
    case (best2_r)
      2'd0:    compsq = sq2_r[0];
      2'd1:    compsq = sq2_r[1];
      default: compsq = sq2_r[2];
    endcase
    ent_nxt.done    = clr | bur | (|corner_in);
    if (clr)
      ent_nxt.verdict = csc_pkg::VERDICT_CLEAR;
    else if (bur || (&corner_in))
      ent_nxt.verdict = csc_pkg::VERDICT_BURIED;
    else
      ent_nxt.verdict = csc_pkg::VERDICT_CROSS;
    ent_nxt.d2     = d2[35:0];
    ent_nxt.compsq = compsq[35:0];
    ent_nxt.dper   = $signed({1'b0, dmin2_r}) - $signed({8'b0, h2_r});
    ent_nxt.sg2    = sg2_r;
    ent_nxt.hh     = hh2_r;
  end

  always_ff @(posedge clk) begin
    ent3_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign mid_push = v3_r;
  assign mid_data = ent3_r;
endmodule
`default_nettype wire

// ===== hw/rtl/csc_back.sv =====
// Back part: nearest-face disc test, four stages, and the result queue.
// Depends on csc_pkg.
`default_nettype none
module csc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 mid_empty,
  input  wire csc_pkg::mid_entry_t  mid_data,
  output logic                      mid_pop,
  input  wire logic                 out_pop,
  output logic                      out_empty,
  output logic [1:0]                out_verdict
);
  logic                 v1_r, v2_r, v3_r, v4_r;
  csc_pkg::mid_entry_t  e1_r;
  // stage 2
  logic                 done2_r;
  csc_pkg::verdict_t    verd2_r, verd3_r, verd4_r, verd_fin;
  logic [41:0]          dpsq2_r;
  logic signed [43:0]   pdp;
  logic [35:0]          dd2_r;
  logic [33:0]          sg2_2_r;
  logic [27:0]          hh2_r, hh3_r;
  // stage 3
  logic                 done3_r, rneg3_r, tpos3_r;
  logic [34:0]          t3_r;
  logic [33:0]          r3_r;
  logic signed [42:0]   r;
  logic signed [37:0]   t;
  // stage 4
  logic                 done4_r, rneg4_r, tpos4_r;
  logic [33:0]          phh_r;
  logic [34:0]          phl_r;
  logic [35:0]          pll_r;
  logic [46:0]          crh_r, crl_r;
  logic [29:0]          cmp2;
  logic [71:0]          t2, cr;
  logic                 le;
  // result queue
  csc_pkg::verdict_t             oq_r [csc_pkg::OUT_DEPTH];
  logic [csc_pkg::OUT_AW-1:0]    wp_r, rp_r;
  logic [csc_pkg::OUT_AW:0]      cnt_r, used_r;
  logic                          opop;

  // used_r counts every request between mid pop and result pop
  assign mid_pop = !mid_empty && (used_r < (csc_pkg::OUT_AW+1)'(csc_pkg::OUT_DEPTH));
  assign opop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    e1_r <= mid_data;
  end

  assign pdp = e1_r.dper * e1_r.dper;

  always_ff @(posedge clk) begin
    done2_r <= e1_r.done;
    verd2_r <= e1_r.verdict;
    dpsq2_r <= pdp[41:0];
    dd2_r   <= e1_r.d2 - e1_r.compsq;
    sg2_2_r <= e1_r.sg2;
    hh2_r   <= e1_r.hh;
  end

  // r = s^2 - q^2, t = dd - r - h^2
  assign r = $signed({9'b0, sg2_2_r}) - $signed({1'b0, dpsq2_r});
  assign t = $signed({2'b0, dd2_r}) - $signed({4'b0, r[33:0]}) - $signed({10'b0, hh2_r});

  always_ff @(posedge clk) begin
    done3_r <= done2_r;
    verd3_r <= verd2_r;
    rneg3_r <= r[42];
    tpos3_r <= !t[37] && (t != '0);
    t3_r    <= t[34:0];
    r3_r    <= r[33:0];
    hh3_r   <= hh2_r;
  end

  // t^2 and 4h^2 r as split partial products
  assign cmp2 = {hh3_r, 2'b00};

  always_ff @(posedge clk) begin
    done4_r <= done3_r;
    verd4_r <= verd3_r;
    rneg4_r <= rneg3_r;
    tpos4_r <= tpos3_r;
    phh_r   <= t3_r[34:18] * t3_r[34:18];
    phl_r   <= t3_r[34:18] * t3_r[17:0];
    pll_r   <= t3_r[17:0] * t3_r[17:0];
    crh_r   <= cmp2 * r3_r[33:17];
    crl_r   <= cmp2 * r3_r[16:0];
  end

  always_comb begin
    t2 = ({38'b0, phh_r} << 36) + ({37'b0, phl_r} << 19) + {36'b0, pll_r};
    cr = ({25'b0, crh_r} << 17) + {25'b0, crl_r};
    le = t2 <= cr;
    if (done4_r)
      verd_fin = verd4_r;
    else if (rneg4_r)
      verd_fin = csc_pkg::VERDICT_CLEAR;
    else if (!tpos4_r || le)
      verd_fin = csc_pkg::VERDICT_CROSS;
    else
      verd_fin = csc_pkg::VERDICT_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (v4_r) begin
      oq_r[wp_r] <= verd_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      used_r <= '0;
    end else begin
      v1_r <= mid_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (v4_r) wp_r <= wp_r + 1'b1;
      if (opop) rp_r <= rp_r + 1'b1;
      cnt_r  <= cnt_r + {{csc_pkg::OUT_AW{1'b0}}, v4_r} - {{csc_pkg::OUT_AW{1'b0}}, opop};
      used_r <= used_r + {{csc_pkg::OUT_AW{1'b0}}, mid_pop} - {{csc_pkg::OUT_AW{1'b0}}, opop};
    end
  end

  assign out_empty   = (cnt_r == '0);
  assign out_verdict = oq_r[rp_r];
endmodule
`default_nettype wire

// ===== test/tb_cube_sphere_classify_unit.sv =====
// Self-checking testbench for cube_sphere_classify_unit: directed and random
// cell/sphere requests checked against a behavioural classifier.
// Depends on csc_pkg and the classifier RTL.
`default_nettype none

module tb_cube_sphere_classify_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 24;  // settling time after the last owed verdict

  // one request as presented on the in_ ports
  typedef struct {
    logic signed [23:0] cx, cy, cz, bx, by, bz;
    logic [15:0]        rad;
  } cell_req_t;

  // Verdict predictor plus the queue of verdicts still owed by the block.
  class verdict_board;
    logic [13:0]          edge_len  = 14'd8192;
    logic [13:0]          half_diag = 14'd7094;
    csc_pkg::verdict_t    owed[$];
    int                   errors  = 0;
    int                   checked = 0;
    int                   hits[3] = '{0, 0, 0};

    // Exact classification; distances are kept doubled so half an edge is whole.
    function csc_pkg::verdict_t classify(cell_req_t q);
      longint dx, dy, dz, sg, sgc, h, sum, diff, d2, sg2, ex, ey, ez, p, dmin;
      longint dper, r, dd, t, cmp;
      longint comp[3];
      logic [127:0] lhs, rhs;
      int n_in, best;
      dx = 2 * (longint'(q.cx) - longint'(q.bx));
      dy = 2 * (longint'(q.cy) - longint'(q.by));
      dz = 2 * (longint'(q.cz) - longint'(q.bz));
      sg = 2 * longint'(q.rad);
      sgc = 2 * longint'(half_diag);
      h = longint'(edge_len);
      sum = sg + sgc;
      diff = (sg > sgc) ? sg - sgc : sgc - sg;
      d2 = dx * dx + dy * dy + dz * dz;
      sg2 = sg * sg;
      if (d2 > sum * sum) return csc_pkg::VERDICT_CLEAR;
      if (d2 < diff * diff) return csc_pkg::VERDICT_BURIED;
      n_in = 0;
      for (int k = 0; k < 8; k++) begin
        ex = dx + (k[0] ? h : -h);
        ey = dy + (k[1] ? h : -h);
        ez = dz + (k[2] ? h : -h);
        if (ex * ex + ey * ey + ez * ez < sg2) n_in++;
      end
      if (n_in == 8) return csc_pkg::VERDICT_BURIED;
      if (n_in != 0) return csc_pkg::VERDICT_CROSS;
      // no corner inside: disc test on the nearest face, first one wins ties
      comp[0] = dx; comp[1] = dy; comp[2] = dz;
      dmin = longint'(10000) << 13;
      best = 0;
      for (int k = 0; k < 6; k++) begin
        p = comp[k >> 1] + (k[0] ? h : -h);
        if (p < 0) p = -p;
        if (p < dmin) begin
          dmin = p;
          best = k;
        end
      end
      dper = dmin - h;
      r = sg2 - dper * dper;
      if (r < 0) return csc_pkg::VERDICT_CLEAR;  // sphere misses the face plane
      dd = d2 - comp[best >> 1] * comp[best >> 1];
      t = dd - r - h * h;
      if (t <= 0) return csc_pkg::VERDICT_CROSS;
      cmp = 2 * h;
      lhs = 128'(t) * 128'(t);
      rhs = 128'(cmp * cmp) * 128'(r);
      return (lhs <= rhs) ? csc_pkg::VERDICT_CROSS : csc_pkg::VERDICT_CLEAR;
    endfunction

    function void note_request(cell_req_t q);
      csc_pkg::verdict_t v;
      v = classify(q);
      hits[v]++;
      owed.push_back(v);
    endfunction

    function void check_verdict(logic [1:0] got);
      csc_pkg::verdict_t want;
      if (owed.size() == 0) begin
        $display("%0t: verdict %0d with no request outstanding", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [23:0] in_cell_x = '0, in_cell_y = '0, in_cell_z = '0;
  logic signed [23:0] in_ball_x = '0, in_ball_y = '0, in_ball_z = '0;
  logic [15:0] in_ball_radius = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [1:0] out_verdict;
  logic cfg_we = 1'b0;
  logic cfg_index = csc_pkg::CFG_CELL_EDGE;
  logic [13:0] cfg_wdata = '0;

  verdict_board board = new();
  bit  steady = 0;     // when set neither side idles
  int  cycles = 0;
  int  pop_hold = 0;

  always #5 clk = ~clk;

  cube_sphere_classify_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_cell_x(in_cell_x), .in_cell_y(in_cell_y), .in_cell_z(in_cell_z),
    .in_ball_x(in_ball_x), .in_ball_y(in_ball_y), .in_ball_z(in_ball_z),
    .in_ball_radius(in_ball_radius),
    .out_empty(out_empty), .out_pop(out_pop), .out_verdict(out_verdict),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Watchdog: ends the run if the block stops making progress.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: values seen at the edge are the pre-edge ones, so the
  // check is race free. A fresh stall is drawn after every popped verdict.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        board.check_verdict(out_verdict);
        pop_hold = steady ? 0 : $urandom_range(0, 6);
      end
      if (pop_hold > 0) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Register write, enable left high; the caller drops it after the last one.
  task automatic write_reg(logic idx, logic [13:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == csc_pkg::CFG_CELL_EDGE) board.edge_len = val;
    else board.half_diag = val;
  endtask

  // Stop sending, wait for every owed verdict, then let the pipeline settle.
  task automatic drain();
    in_push <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_config(logic [13:0] e, logic [13:0] c);
    drain();
    write_reg(csc_pkg::CFG_CELL_EDGE, e);
    write_reg(csc_pkg::CFG_HALF_DIAG, c);
    cfg_we <= 1'b0;
  endtask

  // Present one request, hold it until accepted, then idle for a random gap.
  // in_push stays high between back-to-back requests.
  task automatic send(cell_req_t q);
    int gap;
    in_push <= 1'b1;
    in_cell_x <= q.cx; in_cell_y <= q.cy; in_cell_z <= q.cz;
    in_ball_x <= q.bx; in_ball_y <= q.by; in_ball_z <= q.bz;
    in_ball_radius <= q.rad;
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.note_request(q);
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Request built around a cell at (x, 0, 0)-style offsets from a ball.
  function automatic cell_req_t mk(int cx, int cy, int cz, int bx, int by, int bz, int rad);
    cell_req_t q;
    q.cx = 24'(cx); q.cy = 24'(cy); q.cz = 24'(cz);
    q.bx = 24'(bx); q.by = 24'(by); q.bz = 24'(bz);
    q.rad = 16'(rad);
    return q;
  endfunction

  // Mostly a ball placed within reach of the cell so every branch is hit;
  // some fully random noise to toggle every bit.
  function automatic cell_req_t rand_req();
    cell_req_t q;
    int reach, kind;
    kind = $urandom_range(0, 9);
    q.bx = 24'($urandom); q.by = 24'($urandom); q.bz = 24'($urandom);
    case ($urandom_range(0, 3))
      0: q.rad = 16'($urandom);
      1: q.rad = 16'($urandom_range(0, 2048));
      default: q.rad = 16'($urandom_range(0, 16383));
    endcase
    if (kind == 0) begin
      q.cx = 24'($urandom); q.cy = 24'($urandom); q.cz = 24'($urandom);
    end else begin
      reach = int'(q.rad) + int'(board.half_diag) + 1;
      if (kind < 4) reach = reach / 2 + 1;
      q.cx = 24'(int'(q.bx) + int'($urandom_range(0, 2 * reach)) - reach);
      q.cy = 24'(int'(q.by) + int'($urandom_range(0, 2 * reach)) - reach);
      q.cz = 24'(int'(q.bz) + int'($urandom_range(0, 2 * reach)) - reach);
    end
    return q;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      send(rand_req());
    end
    steady = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset config: edge 2.0, half diagonal ~1.73.
    send(mk(0, 0, 0, 0, 0, 0, 0));                       // zero radius on centre
    send(mk(0, 0, 0, 0, 0, 0, 65535));                   // buried by distance
    send(mk(0, 0, 0, 0, 0, 0, 7094));                    // radius equals half diagonal
    send(mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 65535)); // far
    send(mk(-8388608, 0, 8388607, 8388607, 0, -8388608, 1));
    send(mk(0, 0, 0, 4096, 4096, 4096, 4096));          // sphere on a corner
    send(mk(0, 0, 0, 5096, 0, 0, 2000));                 // face disc hit
    send(mk(0, 0, 0, 7096, 0, 0, 2000));                 // misses face plane
    send(mk(0, 0, 0, 0, -6000, 0, 2000));                // face disc, y side
    send(mk(0, 0, 0, 0, 0, 5800, 2000));                 // face disc, z side
    send(mk(0, 0, 0, 5000, 5000, 0, 1200));              // near an edge, face test
    send(mk(100, -100, 50, 0, 0, 0, 12000));             // all corners inside
    send(mk(0, 0, 0, 6000, 6000, 6000, 2500));           // corner region, clear
    send(mk(0, 0, 0, 0, 0, 0, 4000));                    // buried by distance, centre inside
    steady = 1;
    send(mk(1, 2, 3, -1, -2, -3, 5000));
    send(mk(0, 0, 0, 4096, 0, 0, 0));
    steady = 0;
    run_random(80);

    // Sender pause until every verdict is back.
    drain();
    run_random(20);

    set_config(14'd0, 14'd0);
    send(mk(0, 0, 0, 0, 0, 0, 0));
    send(mk(0, 0, 0, 0, 0, 1, 1));
    run_random(60);

    set_config(14'd16383, 14'd16383);
    send(mk(0, 0, 0, 8191, 0, 0, 100));
    send(mk(0, 0, 0, 0, 0, 0, 65535));
    run_random(60);

    set_config(14'd16383, 14'd0);
    run_random(50);

    set_config(14'd1, 14'd16383);
    run_random(40);

    set_config(14'($urandom), 14'($urandom));
    run_random(50);

    set_config(14'd4096, 14'd3547);
    run_random(40);

    drain();

    $display("checked %0d verdicts over 7 register settings", board.checked);
    $display("buried %0d, crossing %0d, clear %0d",
             board.hits[0], board.hits[1], board.hits[2]);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d errors, %0d verdicts missing", board.errors, board.owed.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
